// ===== design/mi3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared widths, cofactor index tables and the front-to-back word type.
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int EW    = 32;   // element width
	localparam int CW    = 65;   // cofactor width, signed
	localparam int DW    = 99;   // determinant width, signed
	localparam int NCOF  = 9;
	localparam int TW    = 17;   // threshold register width

	// Cofactor i = +/-(e[MA]*e[MB] - e[MC]*e[MD]), element index = col*3 + row
	localparam int MA [NCOF] = '{4, 3, 3, 1, 0, 0, 1, 0, 0};
	localparam int MB [NCOF] = '{8, 8, 7, 8, 8, 7, 5, 5, 4};
	localparam int MC [NCOF] = '{5, 5, 4, 2, 2, 1, 2, 2, 1};
	localparam int MD [NCOF] = '{7, 6, 6, 7, 6, 6, 4, 3, 3};
	localparam logic [NCOF-1:0] MNEG = 9'b010101010;

	typedef struct packed {
		logic [NCOF-1:0][CW-1:0] cof;   // transposed: lane i is output element i
		logic [DW-1:0]           dabs;
		logic                    dneg;
		logic                    sing;
	} front_word_t;

endpackage

// ===== design/mi3_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_front
// Cofactors, determinant and singular classification, seven stages.
// ----------------------------------------------------------------------------
module mi3_front import mi3_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [NCOF-1:0][EW-1:0] elem,
	input  logic [TW-1:0]        thr,
	output logic                 out_valid,
	output front_word_t          out_word
);
	localparam logic [DW:0] HALF = (DW+1)'(1) << (2*FRAC_BITS - 1);

	logic [6:0] v_q;
	logic signed [EW-1:0] e_s1 [NCOF];
	logic signed [2*EW-1:0] p1_s2 [NCOF];
	logic signed [2*EW-1:0] p2_s2 [NCOF];
	logic signed [EW-1:0] ex_s2 [3];
	logic signed [EW-1:0] ex_s3 [3];
	logic signed [CW-1:0] cof_s3 [NCOF];
	logic signed [CW-1:0] cof_s4 [NCOF];
	logic signed [CW-1:0] cof_s5 [NCOF];
	logic signed [CW-1:0] cof_s6 [NCOF];
	logic signed [CW-1:0] lo_s4 [3];
	logic signed [CW-1:0] hi_s4 [3];
	logic signed [DW-1:0] t_s5 [3];
	logic signed [DW-1:0] det_s6;
	logic [DW-1:0] dabs;
	logic [DW:0]   rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[5:0], in_valid};
		end
	end

	always_comb begin
		dabs = det_s6[DW-1] ? DW'(-det_s6) : DW'(det_s6);
		rnd  = ({1'b0, dabs} + HALF) >> (2*FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NCOF; i++) begin
			e_s1[i] <= elem[i];
			p1_s2[i] <= e_s1[MA[i]] * e_s1[MB[i]];
			p2_s2[i] <= e_s1[MC[i]] * e_s1[MD[i]];
			if (MNEG[i]) begin
				cof_s3[i] <= {p2_s2[i][2*EW-1], p2_s2[i]} - {p1_s2[i][2*EW-1], p1_s2[i]};
			end else begin
				cof_s3[i] <= {p1_s2[i][2*EW-1], p1_s2[i]} - {p2_s2[i][2*EW-1], p2_s2[i]};
			end
			cof_s4[i] <= cof_s3[i];
			cof_s5[i] <= cof_s4[i];
			cof_s6[i] <= cof_s5[i];
			// transpose: output element col*3+row takes cofactor row*3+col
			out_word.cof[i] <= cof_s6[(i % 3) * 3 + i / 3];
		end
		for (int j = 0; j < 3; j++) begin
			ex_s2[j] <= e_s1[3*j];
			ex_s3[j] <= ex_s2[j];
			// split the cofactor into a signed high part and an unsigned low word
			lo_s4[j] <= ex_s3[j] * $signed({1'b0, cof_s3[3*j][31:0]});
			hi_s4[j] <= ex_s3[j] * $signed(cof_s3[3*j][CW-1:32]);
			t_s5[j] <= {{(DW-CW-32){hi_s4[j][CW-1]}}, hi_s4[j], 32'b0}
				+ {{(DW-CW){lo_s4[j][CW-1]}}, lo_s4[j]};
		end
		det_s6 <= t_s5[0] + t_s5[1] + t_s5[2];
		out_word.dabs <= dabs;
		out_word.dneg <= det_s6[DW-1];
		out_word.sing <= (dabs == '0) || (rnd < {{(DW+1-TW){1'b0}}, thr});
	end

	assign out_valid = v_q[6];

endmodule

// ===== design/mi3_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_queue
// Two-word queue between the front and the back.
// ----------------------------------------------------------------------------
module mi3_queue import mi3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  front_word_t push_word,
	input  logic        pop_ready,
	output logic        pop_valid,
	output front_word_t pop_word,
	output logic        full
);
	front_word_t mem_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        do_push;
	logic        do_pop;

	assign pop_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign do_pop    = pop_valid && pop_ready;
	assign do_push   = push && (!full || do_pop);
	assign pop_word  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_word;
		end
	end

endmodule

// ===== design/mi3_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_back
// Nine-lane restoring divider, one quotient bit a stage, round and saturate.
// ----------------------------------------------------------------------------
module mi3_back import mi3_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  front_word_t          in_word,
	output logic                 done,
	output logic [NCOF-1:0][EW-1:0] res,
	output logic                 singular
);
	localparam int RW = CW + 2*FRAC_BITS;   // numerator width
	localparam int XW = DW + 32;            // compare width
	localparam int NS = 32;                 // quotient bits

	logic [RW-1:0]   r_s   [NS+1][NCOF];
	logic [NS-1:0]   q_s   [NS+1][NCOF];
	logic [NCOF-1:0] neg_s [NS+1];
	logic [NCOF-1:0] sat_s [NS+1];
	logic [DW-1:0]   d_s   [NS+1];
	logic            sg_s  [NS+1];
	logic [NS+2:0]   v_q;

	logic [NS:0]     qr_s  [NCOF];
	logic [NCOF-1:0] negr_s;
	logic [NCOF-1:0] satr_s;
	logic            sgr_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[NS+1:0], in_valid};
		end
	end

	// Entry stage: magnitudes, signs and the overflow check against D<<32
	always_ff @(posedge clk) begin
		for (int i = 0; i < NCOF; i++) begin
			logic [CW-1:0] mag;
			logic [RW-1:0] num;
			mag = in_word.cof[i][CW-1] ? -in_word.cof[i] : in_word.cof[i];
			num = {mag, {(2*FRAC_BITS){1'b0}}};
			r_s[0][i]   <= num;
			q_s[0][i]   <= '0;
			neg_s[0][i] <= in_word.cof[i][CW-1] ^ in_word.dneg;
			sat_s[0][i] <= ({{(XW-RW){1'b0}}, num} >= {in_word.dabs, 32'b0});
		end
		d_s[0]  <= in_word.dabs;
		sg_s[0] <= in_word.sing;
	end

	for (genvar g = 0; g < NS; g++) begin : g_div
		localparam int K = NS - 1 - g;
		always_ff @(posedge clk) begin
			for (int i = 0; i < NCOF; i++) begin
				logic [XW:0] trial;
				trial = {1'b0, {(XW-RW){1'b0}}, r_s[g][i]}
					- ({1'b0, {(XW-DW){1'b0}}, d_s[g]} << K);
				if (!trial[XW]) begin
					r_s[g+1][i] <= trial[RW-1:0];
				end else begin
					r_s[g+1][i] <= r_s[g][i];
				end
				q_s[g+1][i] <= {q_s[g][i][NS-2:0], ~trial[XW]};
			end
			neg_s[g+1] <= neg_s[g];
			sat_s[g+1] <= sat_s[g];
			d_s[g+1]   <= d_s[g];
			sg_s[g+1]  <= sg_s[g];
		end
	end

	// Round to nearest: bump when twice the remainder reaches the divisor
	always_ff @(posedge clk) begin
		for (int i = 0; i < NCOF; i++) begin
			qr_s[i] <= {1'b0, q_s[NS][i]}
				+ (NS+1)'({{(XW-RW-1){1'b0}}, r_s[NS][i], 1'b0}
				>= {{(XW-DW){1'b0}}, d_s[NS]});
		end
		negr_s <= neg_s[NS];
		satr_s <= sat_s[NS];
		sgr_s  <= sg_s[NS];
	end

	// Saturate, apply sign, zero a singular result
	always_ff @(posedge clk) begin
		for (int i = 0; i < NCOF; i++) begin
			if (sgr_s) begin
				res[i] <= '0;
			end else if (negr_s[i]) begin
				if (satr_s[i] || qr_s[i] > (NS+1)'(33'h080000000)) begin
					res[i] <= 32'h80000000;
				end else begin
					res[i] <= -qr_s[i][EW-1:0];
				end
			end else begin
				if (satr_s[i] || qr_s[i] > (NS+1)'(33'h07FFFFFFF)) begin
					res[i] <= 32'h7FFFFFFF;
				end else begin
					res[i] <= qr_s[i][EW-1:0];
				end
			end
		end
		singular <= sgr_s;
	end

	assign done = v_q[NS+2];

endmodule

// ===== design/matrix_inverse_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Q16.16 3x3 inverse by adjugate over determinant, with a singular check.
// ----------------------------------------------------------------------------
// Throughput: one matrix per cycle; the 32-stage nine-lane divider sets the
// depth, the receiver cannot stall so the queue never fills and busy stays low.
// Reset: clears all valid flags and the queue, thr_q returns to 1;
// the data path registers are not reset.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 import mi3_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 cfg_we,
	input  logic [TW-1:0]        cfg_data,
	input  logic signed [EW-1:0] col0_row0,
	input  logic signed [EW-1:0] col0_row1,
	input  logic signed [EW-1:0] col0_row2,
	input  logic signed [EW-1:0] col1_row0,
	input  logic signed [EW-1:0] col1_row1,
	input  logic signed [EW-1:0] col1_row2,
	input  logic signed [EW-1:0] col2_row0,
	input  logic signed [EW-1:0] col2_row1,
	input  logic signed [EW-1:0] col2_row2,
	output logic                 done,
	output logic signed [EW-1:0] inv_col0_row0,
	output logic signed [EW-1:0] inv_col0_row1,
	output logic signed [EW-1:0] inv_col0_row2,
	output logic signed [EW-1:0] inv_col1_row0,
	output logic signed [EW-1:0] inv_col1_row1,
	output logic signed [EW-1:0] inv_col1_row2,
	output logic signed [EW-1:0] inv_col2_row0,
	output logic signed [EW-1:0] inv_col2_row1,
	output logic signed [EW-1:0] inv_col2_row2,
	output logic                 singular
);
	logic [TW-1:0]           thr_q;
	logic [NCOF-1:0][EW-1:0] elem;
	logic [NCOF-1:0][EW-1:0] res;
	logic                    accept;
	logic                    f_valid;
	front_word_t             f_word;
	logic                    b_valid;
	front_word_t             b_word;
	logic                    q_full;

	// Hold the threshold; writes must arrive only while the block is idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= TW'(1);
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	assign accept = start && !busy;
	assign busy   = q_full;

	// Element index is column*3 + row
	assign elem = {col2_row2, col2_row1, col2_row0,
		col1_row2, col1_row1, col1_row0,
		col0_row2, col0_row1, col0_row0};

	// Front: cofactors and determinant, classify each word as singular or not
	mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.elem      (elem),
		.thr       (thr_q),
		.out_valid (f_valid),
		.out_word  (f_word)
	);

	// Queue: decouple front from back; the back always drains it
	mi3_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.push_word (f_word),
		.pop_ready (1'b1),
		.pop_valid (b_valid),
		.pop_word  (b_word),
		.full      (q_full)
	);

	// Back: divide each cofactor by the determinant, round and saturate
	mi3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (b_valid),
		.in_word  (b_word),
		.done     (done),
		.res      (res),
		.singular (singular)
	);

	assign inv_col0_row0 = res[0];
	assign inv_col0_row1 = res[1];
	assign inv_col0_row2 = res[2];
	assign inv_col1_row0 = res[3];
	assign inv_col1_row1 = res[4];
	assign inv_col1_row2 = res[5];
	assign inv_col2_row0 = res[6];
	assign inv_col2_row1 = res[7];
	assign inv_col2_row2 = res[8];

endmodule

// ===== tb/matrix_inverse_3x3_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_tb
// Streams 3x3 Q16.16 matrices through the inverter under several singular
// thresholds and checks every result word against an exact wide-integer
// adjugate/determinant predictor held in a small scoreboard class.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_tb;
	import mi3_pkg::*;

	localparam int FRAC     = 16;
	localparam int LATENCY  = 43;
	localparam int WD_LIMIT = 2000;
	localparam int N_RANDOM = 800;

	typedef logic signed [EW-1:0] elem_t;
	typedef elem_t mat_t [9];

	typedef struct {
		elem_t inv [9];
		logic  sing;
	} inverse_t;

	// Exact inverse predictor plus the queue of inverses still owed by the block.
	class inverse_board;
		inverse_t         pending [$];
		logic [TW-1:0]    thresh;
		int               n_err;

		function new();
			thresh = 1;
			n_err  = 0;
		endfunction

		function inverse_t predict(mat_t e);
			logic signed [127:0] cof [9];
			logic signed [127:0] det, dabs, rd, num, q, r, c;
			inverse_t            res;
			int                  col, row;
			// cofactor k = row*3+col of element (col,row); element index = col*3+row
			for (int k = 0; k < 9; k++) begin
				int ca, cb, ra, rb, rw, cl;
				rw = k / 3;
				cl = k % 3;
				ca = (cl == 0) ? 1 : 0;
				cb = (cl == 2) ? 1 : 2;
				ra = (rw == 0) ? 1 : 0;
				rb = (rw == 2) ? 1 : 2;
				cof[k] = 128'(e[ca*3+ra]) * 128'(e[cb*3+rb])
					- 128'(e[ca*3+rb]) * 128'(e[cb*3+ra]);
				if ((rw + cl) % 2 == 1)
					cof[k] = -cof[k];
			end
			det  = 128'(e[0]) * cof[0] + 128'(e[1]) * cof[3] + 128'(e[2]) * cof[6];
			dabs = (det < 0) ? -det : det;
			rd   = (dabs + (128'sd1 <<< (2*FRAC - 1))) >>> (2*FRAC);
			if (dabs == 0 || rd < $signed({111'd0, thresh})) begin
				foreach (res.inv[i]) res.inv[i] = '0;
				res.sing = 1'b1;
				return res;
			end
			for (int i = 0; i < 9; i++) begin
				col = i / 3;
				row = i % 3;
				// adjugate: element (col,row) takes the cofactor of element (row,col)
				c   = cof[col*3 + row];
				num = ((c < 0) ? -c : c) <<< (2*FRAC);
				q   = num / dabs;
				r   = num % dabs;
				if (2 * r >= dabs)
					q = q + 1;
				if ((c < 0) != (det < 0))
					res.inv[i] = (q > 128'sh80000000) ? elem_t'(32'h80000000) : elem_t'(-q);
				else
					res.inv[i] = (q > 128'sh7FFFFFFF) ? elem_t'(32'h7FFFFFFF) : elem_t'(q);
			end
			res.sing = 1'b0;
			return res;
		endfunction

		function void note_matrix(mat_t e);
			pending.push_back(predict(e));
		endfunction

		function void check_inverse(inverse_t got);
			inverse_t want;
			if (pending.size() == 0) begin
				$error("inverse word with none outstanding");
				n_err++;
				return;
			end
			want = pending.pop_front();
			for (int i = 0; i < 9; i++)
				if (got.inv[i] !== want.inv[i]) begin
					$error("inv_col%0d_row%0d: expected %h, actual %h",
						i / 3, i % 3, want.inv[i], got.inv[i]);
					n_err++;
				end
			if (got.sing !== want.sing) begin
				$error("singular: expected %b, actual %b", want.sing, got.sing);
				n_err++;
			end
		endfunction
	endclass

	logic          clk, arst_n, start, busy, cfg_we, done, singular;
	logic [TW-1:0] cfg_data;
	elem_t         a [9];
	elem_t         y [9];
	inverse_board  board;
	int            idle_cycles;
	int            n_sent;
	bit            quiet;

	matrix_inverse_3x3 u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.col0_row0     (a[0]),
		.col0_row1     (a[1]),
		.col0_row2     (a[2]),
		.col1_row0     (a[3]),
		.col1_row1     (a[4]),
		.col1_row2     (a[5]),
		.col2_row0     (a[6]),
		.col2_row1     (a[7]),
		.col2_row2     (a[8]),
		.done          (done),
		.inv_col0_row0 (y[0]),
		.inv_col0_row1 (y[1]),
		.inv_col0_row2 (y[2]),
		.inv_col1_row0 (y[3]),
		.inv_col1_row1 (y[4]),
		.inv_col1_row2 (y[5]),
		.inv_col2_row0 (y[6]),
		.inv_col2_row1 (y[7]),
		.inv_col2_row2 (y[8]),
		.singular      (singular)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample result words at the edge; each word is shown for exactly one cycle.
	always @(posedge clk) begin
		inverse_t got;
		if (arst_n && done) begin
			foreach (got.inv[i]) got.inv[i] = y[i];
			got.sing = singular;
			board.check_inverse(got);
		end
	end

	// Watchdog: count cycles in which no word moves in either direction.
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Drive one matrix; hold start until the block takes it.
	task automatic send_matrix(mat_t m);
		if (!quiet)
			while ($urandom_range(99) < 15) begin
				start <= 1'b0;
				@(posedge clk);
			end
		start <= 1'b1;
		foreach (m[i]) a[i] <= m[i];
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_matrix(m);
		n_sent++;
	endtask

	// Drain the pipe, then write the threshold while the block is idle.
	task automatic set_threshold(logic [TW-1:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		board.thresh = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic elem_t rand_elem();
		case ($urandom_range(5))
			0:       return elem_t'($urandom);
			1:       return elem_t'($signed($urandom_range(131072)) - 65536);
			2:       return ($urandom_range(1)) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: return elem_t'($signed($urandom_range(1 << 20)) - (1 << 19));
		endcase
	endfunction

	// Random matrix: some diagonally dominant, some plain random, some near singular, some rank deficient.
	function automatic mat_t rand_matrix();
		mat_t m;
		int   kind;
		kind = $urandom_range(9);
		foreach (m[i]) m[i] = rand_elem();
		if (kind == 0) begin
			// drop the rank: column 2 copies column 0
			for (int r = 0; r < 3; r++) m[6 + r] = m[r];
		end else if (kind == 1) begin
			// tiny elements push the determinant around the threshold
			foreach (m[i]) m[i] = elem_t'($signed($urandom_range(1024)) - 512);
		end else if (kind <= 5) begin
			// diagonally dominant, invertible in range
			foreach (m[i]) m[i] = elem_t'($signed($urandom_range(32768)) - 16384);
			for (int d = 0; d < 3; d++)
				m[d*4] = elem_t'(($urandom_range(1) ? 1 : -1) * $signed($urandom_range(1 << 20)
					+ 65536));
		end
		return m;
	endfunction

	initial begin
		mat_t m;
		int   thr [5];
		board    = new();
		arst_n   = 1'b0;
		start    = 1'b0;
		cfg_we   = 1'b0;
		cfg_data = '0;
		foreach (a[i]) a[i] = '0;
		idle_cycles = 0;
		n_sent = 0;
		quiet  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: identity, scaled, zero, extremes, singular, overflow.
		foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh00010000 : 32'sh0;
		send_matrix(m);
		foreach (m[i]) m[i] = (i % 4 == 0) ? 32'shFFFE0000 : 32'sh0;
		send_matrix(m);
		foreach (m[i]) m[i] = '0;
		send_matrix(m);
		foreach (m[i]) m[i] = 32'sh7FFFFFFF;
		send_matrix(m);
		foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh80000000 : 32'sh0;
		send_matrix(m);
		foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh7FFFFFFF : 32'sh80000000;
		send_matrix(m);
		foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh00000100 : 32'sh0;   // tiny det
		send_matrix(m);
		foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh00000001 : 32'sh0;   // det rounds to zero
		send_matrix(m);
		foreach (m[i]) m[i] = (i % 4 == 0) ? 32'shFFFFFFFF : 32'sh0;
		send_matrix(m);
		foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh00010000 : 32'sh0;
		m[0] = 32'sh00000080;   // det rounds half up to the threshold of 1
		m[4] = 32'sh00000100;
		send_matrix(m);
		for (int i = 0; i < 9; i++) m[i] = elem_t'(i * 32'sh00010000);
		send_matrix(m);

		// Exact zero determinant must stay singular at threshold 0.
		set_threshold('0);
		send_matrix(m);
		foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh00000001 : 32'sh0;
		send_matrix(m);

		// Random phases across thresholds, extremes included.
		thr = '{0, 65536, 1, 256, -1};
		for (int p = 0; p < 5; p++) begin
			set_threshold((thr[p] < 0) ? TW'($urandom_range(65536)) : TW'(thr[p]));
			for (int n = 0; n < N_RANDOM / 5; n++) begin
				quiet = (p == 2);   // one phase at full rate
				send_matrix(rand_matrix());
			end
		end
		quiet = 1'b0;
		start <= 1'b0;
		@(posedge clk);

		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (board.n_err == 0 && board.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
